### design/rf_path_relay_switch_controller_macros.svh
// Assertion macros used by the checker file of the relay switch controller.
`ifndef RF_PATH_RELAY_SWITCH_CONTROLLER_MACROS_SVH
`define RF_PATH_RELAY_SWITCH_CONTROLLER_MACROS_SVH

// Checked property that is ignored while reset is asserted.
`define RFSW_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that must also hold during reset.
`define RFSW_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/rfsw_pkg.sv
// Shared types, constants and register codes of the relay switch controller.
package rfsw_pkg;

	localparam int SAMPLES_PER_POLL = 8;
	localparam int AGE_BITS         = 32;

	localparam int SAMPLE_PORTS = 8;
	localparam int SAMPLE_W     = 12;
	localparam int SUM_W        = SAMPLE_W + $clog2(SAMPLES_PER_POLL);
	localparam int AGE_OUT_W    = 32;
	localparam int DELAY_W      = 16;
	localparam int ADDR_W       = 5;
	localparam int DATA_W       = 32;
	localparam int REG_IDX_W    = 3;

	localparam logic [11:0] THRESHOLD_RST = 12'd496;
	localparam logic [15:0] DELAY_RST     = 16'd120;
	localparam logic [15:0] PERIOD_RST    = 16'd10000;
	localparam logic [15:0] ON_RST        = 16'd1000;

	typedef enum logic [1:0] {
		MODE_SENSE    = 2'd0,
		MODE_TX       = 2'd1,
		MODE_RX       = 2'd2,
		MODE_BAD_CODE = 2'd3
	} mode_t;

	// An override value equal to this code hands mode selection to the switch.
	localparam mode_t OVERRIDE_USE_SWITCH = MODE_BAD_CODE;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_THRESHOLD = 3'd0,
		REG_DELAY     = 3'd1,
		REG_PERIOD    = 3'd2,
		REG_ON        = 3'd3,
		REG_OVERRIDE  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [11:0]      detect_threshold;
		logic [15:0]      relay_delay_ticks;
		logic [15:0]      led_period_ticks;
		logic [15:0]      led_on_ticks;
		mode_t            mode_override;
	} cfg_t;

endpackage

### design/rfsw_regs.sv
// APB-style configuration register file of the relay switch controller.
module rfsw_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rfsw_pkg::ADDR_W-1:0] paddr,
	input  logic [rfsw_pkg::DATA_W-1:0] pwdata,
	output logic [rfsw_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output rfsw_pkg::cfg_t             cfg
);
	import rfsw_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.detect_threshold  <= THRESHOLD_RST;
			cfg_q.relay_delay_ticks <= DELAY_RST;
			cfg_q.led_period_ticks  <= PERIOD_RST;
			cfg_q.led_on_ticks      <= ON_RST;
			cfg_q.mode_override     <= OVERRIDE_USE_SWITCH;
		end else if (wr_en) begin
			unique case (idx)
				REG_THRESHOLD: cfg_q.detect_threshold  <= pwdata[11:0];
				REG_DELAY:     cfg_q.relay_delay_ticks <= pwdata[15:0];
				REG_PERIOD:    cfg_q.led_period_ticks  <= pwdata[15:0];
				REG_ON:        cfg_q.led_on_ticks      <= pwdata[15:0];
				REG_OVERRIDE:  cfg_q.mode_override     <= mode_t'(pwdata[1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_THRESHOLD: prdata = DATA_W'(cfg_q.detect_threshold);
			REG_DELAY:     prdata = DATA_W'(cfg_q.relay_delay_ticks);
			REG_PERIOD:    prdata = DATA_W'(cfg_q.led_period_ticks);
			REG_ON:        prdata = DATA_W'(cfg_q.led_on_ticks);
			REG_OVERRIDE:  prdata = DATA_W'(cfg_q.mode_override);
			default:       prdata = '0;
		endcase
	end

endmodule

### design/rf_path_relay_switch_controller.sv
// Top level of the RF path relay switch controller.
//
//   Channel  Handshake            Contents
//   -------  -------------------  -----------------------------------------------
//   input    in_valid / in_stall  switch bits and eight detector samples per poll
//   output   out_valid/out_stall  relay drives, path and mode status, LED, age
//   config   psel/penable/pready  five registers at byte address 4*index
//
// One poll transaction is accepted per clock cycle unless in_stall is raised. A
// transaction is held in the input register, and its result is then written
// into the result register. The sample adder chain and threshold compare
// between those two registers set the cycle time.
// Reset clears all control state and restores the register defaults.
// in_stall is raised only when the input register is full and the result
// register holds a transaction that the receiver is stalling.
module rf_path_relay_switch_controller (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rfsw_pkg::ADDR_W-1:0]  paddr,
	input  logic [rfsw_pkg::DATA_W-1:0]  pwdata,
	output logic [rfsw_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,

	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         switch_auto,
	input  logic                         switch_force_tx,
	input  logic                         switch_force_rx,
	input  logic [11:0]                  sample_0,
	input  logic [11:0]                  sample_1,
	input  logic [11:0]                  sample_2,
	input  logic [11:0]                  sample_3,
	input  logic [11:0]                  sample_4,
	input  logic [11:0]                  sample_5,
	input  logic [11:0]                  sample_6,
	input  logic [11:0]                  sample_7,

	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         relay_path,
	output logic                         relay_load,
	output logic                         path_state,
	output logic                         switching,
	output logic [1:0]                   active_mode,
	output logic                         mode_from_override,
	output logic                         status_led,
	output logic                         detect_ever,
	output logic [31:0]                  detect_age_ticks
);
	import rfsw_pkg::*;

	// Relay sequence: the first relay has flipped in WAIT1, the second in WAIT2.
	typedef enum logic [1:0] {
		SEQ_IDLE  = 2'd0,
		SEQ_WAIT1 = 2'd1,
		SEQ_WAIT2 = 2'd2
	} seq_state_t;

	cfg_t cfg;

	rfsw_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input register. The payload needs no reset; only its valid bit does.
	logic                  valid_s1;
	logic [2:0]            switch_s1;
	logic [SAMPLE_W-1:0]   samp_s1 [SAMPLE_PORTS];

	// Result register. The controller state doubles as the result, because
	// every output field is the state left behind by the latest transaction.
	logic                  out_valid_q;
	seq_state_t            seq_q;
	logic                  path_q;
	logic                  path_relay_q;
	logic                  load_relay_q;
	logic                  target_q;
	logic [DELAY_W-1:0]    delay_q;
	logic [15:0]           phase_q;
	logic                  led_q;
	logic                  seen_q;
	logic [AGE_BITS-1:0]   age_q;
	mode_t                 mode_q;
	logic                  from_ovr_q;

	// The result register takes a transaction whenever it is empty or drained.
	logic advance;
	assign advance  = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			switch_s1  <= {switch_force_rx, switch_force_tx, switch_auto};
			samp_s1[0] <= sample_0;
			samp_s1[1] <= sample_1;
			samp_s1[2] <= sample_2;
			samp_s1[3] <= sample_3;
			samp_s1[4] <= sample_4;
			samp_s1[5] <= sample_5;
			samp_s1[6] <= sample_6;
			samp_s1[7] <= sample_7;
		end
	end

	// Mode selection. The override register wins unless it asks for the switch;
	// the switch must show exactly one position, anything else is invalid and
	// acts as receive.
	logic  from_ovr;
	mode_t sw_mode;
	mode_t mode;

	always_comb begin
		unique case (switch_s1)
			3'b001:  sw_mode = MODE_SENSE;
			3'b010:  sw_mode = MODE_TX;
			3'b100:  sw_mode = MODE_RX;
			default: sw_mode = MODE_BAD_CODE;
		endcase
	end

	assign from_ovr = (cfg.mode_override != OVERRIDE_USE_SWITCH);
	assign mode     = from_ovr ? cfg.mode_override : sw_mode;

	// Auto detection. Comparing the sum against threshold times the sample
	// count is the same as comparing the floored average against the threshold.
	logic [SUM_W-1:0] sample_sum;
	logic [SUM_W-1:0] thr_scaled;
	logic             avg_hit;

	always_comb begin
		sample_sum = '0;
		for (int i = 0; i < SAMPLES_PER_POLL; i++) begin
			sample_sum = sample_sum + SUM_W'(samp_s1[i]);
		end
	end

	assign thr_scaled = SUM_W'(cfg.detect_threshold) * SUM_W'(SAMPLES_PER_POLL);
	assign avg_hit    = (sample_sum >= thr_scaled);

	// A zero delay register behaves as a one-tick delay.
	logic [DELAY_W-1:0] delay_load;
	assign delay_load = (cfg.relay_delay_ticks == '0) ? DELAY_W'(1) : cfg.relay_delay_ticks;

	// Per-tick controller update.
	seq_state_t         seq_d;
	logic               path_d;
	logic               path_relay_d;
	logic               load_relay_d;
	logic               target_d;
	logic [DELAY_W-1:0] delay_d;
	logic               led_update;
	logic               detected;
	logic               desired;

	always_comb begin
		seq_d        = seq_q;
		path_d       = path_q;
		path_relay_d = path_relay_q;
		load_relay_d = load_relay_q;
		target_d     = target_q;
		delay_d      = delay_q;
		led_update   = 1'b0;
		detected     = 1'b0;
		desired      = 1'b0;

		unique case (seq_q)
			SEQ_WAIT1, SEQ_WAIT2: begin
				if (delay_q > DELAY_W'(1)) begin
					delay_d = delay_q - DELAY_W'(1);
				end else if (seq_q == SEQ_WAIT1) begin
					// Make the second contact: load passthrough on the way to
					// transmit, path relay back to receive otherwise.
					if (target_q) begin
						load_relay_d = 1'b1;
					end else begin
						path_relay_d = 1'b0;
					end
					delay_d = delay_load;
					seq_d   = SEQ_WAIT2;
				end else begin
					delay_d    = '0;
					path_d     = target_q;
					seq_d      = SEQ_IDLE;
					led_update = 1'b1;
				end
			end
			default: begin
				// Idle. The decoded mode only acts here.
				if (mode == MODE_TX) begin
					desired = 1'b1;
				end else if (mode == MODE_SENSE) begin
					desired  = avg_hit;
					detected = avg_hit;
				end
				if (desired != path_q) begin
					// Break first: path relay on toward transmit, load relay
					// off (dummy load) toward receive.
					target_d = desired;
					if (desired) begin
						path_relay_d = 1'b1;
					end else begin
						load_relay_d = 1'b0;
					end
					delay_d = delay_load;
					seq_d   = SEQ_WAIT1;
				end else begin
					led_update = 1'b1;
				end
			end
		endcase
	end

	// LED is solid in transmit and lit for the first part of each blink period
	// in receive; it freezes while a relay sequence runs.
	logic        led_d;
	logic [16:0] phase_inc;
	logic [15:0] phase_d;

	assign led_d     = led_update ? (path_d || (phase_q < cfg.led_on_ticks)) : led_q;
	assign phase_inc = {1'b0, phase_q} + 17'd1;
	assign phase_d   = (phase_inc >= {1'b0, cfg.led_period_ticks}) ? '0 : phase_inc[15:0];

	// Age since last detection, counting only once something has been seen.
	logic                seen_d;
	logic [AGE_BITS-1:0] age_d;

	always_comb begin
		seen_d = seen_q;
		age_d  = age_q;
		if (detected) begin
			seen_d = 1'b1;
			age_d  = '0;
		end else if (seen_q && (age_q != {AGE_BITS{1'b1}})) begin
			age_d = age_q + AGE_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			seq_q        <= SEQ_IDLE;
			path_q       <= 1'b0;
			path_relay_q <= 1'b0;
			load_relay_q <= 1'b0;
			target_q     <= 1'b0;
			delay_q      <= '0;
			phase_q      <= '0;
			led_q        <= 1'b0;
			seen_q       <= 1'b0;
			age_q        <= '0;
			mode_q       <= MODE_SENSE;
			from_ovr_q   <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q  <= 1'b1;
				seq_q        <= seq_d;
				path_q       <= path_d;
				path_relay_q <= path_relay_d;
				load_relay_q <= load_relay_d;
				target_q     <= target_d;
				delay_q      <= delay_d;
				phase_q      <= phase_d;
				led_q        <= led_d;
				seen_q       <= seen_d;
				age_q        <= age_d;
				mode_q       <= mode;
				from_ovr_q   <= from_ovr;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid          = out_valid_q;
	assign relay_path         = path_relay_q;
	assign relay_load         = load_relay_q;
	assign path_state         = path_q;
	assign switching          = (seq_q != SEQ_IDLE);
	assign active_mode        = mode_q;
	assign mode_from_override = from_ovr_q;
	assign status_led         = led_q;
	assign detect_ever        = seen_q;
	assign detect_age_ticks   = seen_q ? AGE_OUT_W'(age_q) : '0;

endmodule

### design/rfsw_checker.sv
// Port-level checker of the relay switch controller and its bind statement.
`include "rf_path_relay_switch_controller_macros.svh"

module rfsw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        relay_path,
	input logic        relay_load,
	input logic        path_state,
	input logic        switching,
	input logic        detect_ever,
	input logic [31:0] detect_age_ticks
);

	// A stalled result stays offered.
	`RFSW_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid, "result dropped while stalled")

	// Input back-pressure only comes from a stalled result.
	`RFSW_ASSERT(a_stall_cause, clk, arst_n, in_stall |-> out_valid && out_stall, "input stalled without a stalled result")

	// Break before make: the load never passes through on the receive path.
	`RFSW_ASSERT(a_break_make, clk, arst_n, out_valid |-> !(relay_load && !relay_path), "load relay made while path relay on receive")

	// With no sequence running both relays sit at the settled path.
	`RFSW_ASSERT(a_settled, clk, arst_n, out_valid && !switching |-> relay_path == path_state && relay_load == path_state, "relays disagree with settled path")

	// Age reads zero until the first detection.
	`RFSW_ASSERT(a_age_zero, clk, arst_n, out_valid && !detect_ever |-> detect_age_ticks == 32'd0, "age nonzero before any detection")

endmodule

bind rf_path_relay_switch_controller rfsw_checker u_rfsw_checker (.*);
